FILE: src/vsic_pkg.sv
// Package for the VLAN ingress classifier: status codes, commands, tag constants,
// queue item type and scan state enum. No dependencies.
package vsic_pkg;

   localparam logic [1:0] ST_MATCHED   = 2'd0;
   localparam logic [1:0] ST_NOMATCH   = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;
   localparam logic [1:0] ST_WRITTEN   = 2'd3;

   localparam logic CMD_CLASSIFY = 1'b0;
   localparam logic CMD_WRITE    = 1'b1;

   localparam logic [15:0] TPID_CTAG   = 16'h8100;
   localparam logic [15:0] TPID_STAG   = 16'h88A8;
   localparam logic [11:0] VID_MASK    = 12'hfff;
   localparam int          DEI_POS     = 12;
   localparam int          PCP_POS     = 13;
   localparam logic [15:0] BASE_HEADER = 16'd14;

   typedef struct packed {
      logic        cmd;
      logic [15:0] port;
      logic [15:0] frame_length;
      logic [15:0] word_a;
      logic [15:0] word_b;
      logic [15:0] word_c;
      logic [15:0] word_d;
      logic [15:0] word_e;
      logic [3:0]  entry_slot;
      logic        entry_enable;
      logic [1:0]  entry_tags;
      logic [31:0] entry_logical;
   } item_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONTRACT,
      S_CHECK,
      S_MATCH,
      S_DONE
   } scan_state_type;

endpackage

FILE: src/vsic_queue.sv
// Two-entry item queue between the front end and the table engine.
// Depends on vsic_pkg.
module vsic_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  vsic_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output vsic_pkg::item_type out_item
);
   import vsic_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !in_ready)
      else $error("queue full but ready");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop && count_ff != 2'd2 |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not advance");
   a_empty_no_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd0 |-> !out_valid)
      else $error("empty queue shows valid");

endmodule

FILE: src/vsic_engine.sv
// Table engine: holds the attachment table and scans it one slot per cycle
// for the port contract and then the VLAN key match. Depends on vsic_pkg.
module vsic_engine #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_ready,
   input  vsic_pkg::item_type item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_logical_id,
   output logic [2:0]         rsp_outer_pcp,
   output logic               rsp_outer_dei,
   output logic [2:0]         rsp_inner_pcp,
   output logic               rsp_inner_dei,
   output logic [3:0]         rsp_strip_octets
);
   import vsic_pkg::*;

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   // table storage
   logic                     valid_ff [TABLE_ENTRIES];
   logic [15:0]              tport_ff [TABLE_ENTRIES];
   logic [1:0]               ttags_ff [TABLE_ENTRIES];
   logic [11:0]              tovid_ff [TABLE_ENTRIES];
   logic [11:0]              tivid_ff [TABLE_ENTRIES];
   logic [31:0]              ttpid_ff [TABLE_ENTRIES];
   logic [31:0]              tlog_ff  [TABLE_ENTRIES];

   scan_state_type state_ff, state_in;
   item_type       cur_ff, cur_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [IW-1:0]  idx;
   logic [1:0]     ctags_ff, ctags_in;
   logic [31:0]    ctpid_ff, ctpid_in;
   logic [11:0]    kov_ff, kov_in;
   logic [11:0]    kiv_ff, kiv_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic [31:0] out_logical_ff, out_logical_in;
   logic [2:0]  out_opcp_ff, out_opcp_in, out_ipcp_ff, out_ipcp_in;
   logic        out_odei_ff, out_odei_in, out_idei_ff, out_idei_in;
   logic [3:0]  out_strip_ff, out_strip_in;

   logic        take, do_write, finish;
   logic [1:0]  fin_status;
   logic [31:0] fin_logical;
   logic [15:0] need_len, ext_word;
   logic [11:0] ov_sel, iv_sel;
   logic        tpid_bad, extra;
   logic        slot_hit;

   assign idx        = idx_ff[IW-1:0];
   assign item_ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign take       = item_valid && item_ready;
   assign do_write   = take && (item.cmd == CMD_WRITE);

   // header checks against the latched contract
   always_comb begin
      need_len = BASE_HEADER + {12'd0, ctags_ff, 2'b00};
      tpid_bad = 1'b0;
      ov_sel   = kov_ff;
      iv_sel   = kiv_ff;
      if (ctags_ff >= 2'd1) begin
         tpid_bad = tpid_bad || (cur_ff.word_a != ctpid_ff[31:16]);
         ov_sel   = cur_ff.word_b[11:0] & VID_MASK;
      end
      if (ctags_ff == 2'd2) begin
         tpid_bad = tpid_bad || (cur_ff.word_c != ctpid_ff[15:0]);
         iv_sel   = cur_ff.word_d[11:0] & VID_MASK;
      end
      case (ctags_ff)
         2'd0:    ext_word = cur_ff.word_a;
         2'd1:    ext_word = cur_ff.word_c;
         default: ext_word = cur_ff.word_e;
      endcase
      extra = (ext_word == TPID_CTAG) || (ext_word == TPID_STAG) ||
              (ext_word == ctpid_ff[31:16]) ||
              ((ctpid_ff[15:0] != 16'd0) && (ext_word == ctpid_ff[15:0]));
   end

   assign slot_hit = valid_ff[idx] && (tport_ff[idx] == cur_ff.port) &&
                     (ttags_ff[idx] == ctags_ff) && (tovid_ff[idx] == kov_ff) &&
                     (tivid_ff[idx] == kiv_ff) && (ttpid_ff[idx] == ctpid_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (take && item.cmd == CMD_CLASSIFY) begin
               state_in = S_CONTRACT;
            end
         end
         S_CONTRACT: begin
            if (valid_ff[idx] && tport_ff[idx] == cur_ff.port) begin
               state_in = S_CHECK;
            end else if (idx_ff == CW'(TABLE_ENTRIES - 1)) begin
               state_in = S_DONE;
            end
         end
         S_CHECK: begin
            if (ctags_ff > 2'd2 || cur_ff.frame_length < need_len || tpid_bad || extra) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            if (slot_hit || idx_ff == CW'(TABLE_ENTRIES - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cur_in      = cur_ff;
      idx_in      = idx_ff;
      ctags_in    = ctags_ff;
      ctpid_in    = ctpid_ff;
      kov_in      = kov_ff;
      kiv_in      = kiv_ff;
      finish      = 1'b0;
      fin_status  = ST_NOMATCH;
      fin_logical = 32'd0;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               cur_in = item;
               idx_in = '0;
            end
            if (do_write) begin
               finish     = 1'b1;
               fin_status = ST_WRITTEN;
            end
         end
         S_CONTRACT: begin
            if (valid_ff[idx] && tport_ff[idx] == cur_ff.port) begin
               ctags_in = ttags_ff[idx];
               ctpid_in = ttpid_ff[idx];
               kov_in   = tovid_ff[idx];
               kiv_in   = tivid_ff[idx];
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_CHECK: begin
            idx_in = '0;
            kov_in = ov_sel;
            kiv_in = iv_sel;
            if (ctags_ff <= 2'd2 && cur_ff.frame_length < need_len) begin
               fin_status = ST_MALFORMED;
            end
         end
         S_MATCH: begin
            if (!slot_hit) begin
               idx_in = idx_ff + CW'(1);
            end
         end
         default: ;
      endcase
   end

   // result register
   always_comb begin
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_status_in  = out_status_ff;
      out_logical_in = out_logical_ff;
      out_opcp_in    = out_opcp_ff;
      out_odei_in    = out_odei_ff;
      out_ipcp_in    = out_ipcp_ff;
      out_idei_in    = out_idei_ff;
      out_strip_in   = out_strip_ff;
      if (finish || (state_ff == S_CONTRACT && state_in == S_DONE) ||
          (state_ff == S_CHECK && state_in == S_DONE) ||
          (state_ff == S_MATCH && state_in == S_DONE)) begin
         out_valid_in   = 1'b1;
         out_status_in  = fin_status;
         out_logical_in = fin_logical;
         out_opcp_in    = 3'd0;
         out_odei_in    = 1'b0;
         out_ipcp_in    = 3'd0;
         out_idei_in    = 1'b0;
         out_strip_in   = 4'd0;
         if (state_ff == S_MATCH && slot_hit) begin
            out_status_in  = ST_MATCHED;
            out_logical_in = tlog_ff[idx];
            out_strip_in   = {ctags_ff, 2'b00};
            if (ctags_ff >= 2'd1) begin
               out_opcp_in = cur_ff.word_b[PCP_POS+:3];
               out_odei_in = cur_ff.word_b[DEI_POS];
            end
            if (ctags_ff == 2'd2) begin
               out_ipcp_in = cur_ff.word_d[PCP_POS+:3];
               out_idei_in = cur_ff.word_d[DEI_POS];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      idx_ff         <= idx_in;
      ctags_ff       <= ctags_in;
      ctpid_ff       <= ctpid_in;
      kov_ff         <= kov_in;
      kiv_ff         <= kiv_in;
      out_status_ff  <= out_status_in;
      out_logical_ff <= out_logical_in;
      out_opcp_ff    <= out_opcp_in;
      out_odei_ff    <= out_odei_in;
      out_ipcp_ff    <= out_ipcp_in;
      out_idei_ff    <= out_idei_in;
      out_strip_ff   <= out_strip_in;
   end

   // valid bits clear on reset; payload only on write
   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (do_write && {1'b0, item.entry_slot} == 5'(i)) begin
            valid_ff[i] <= item.entry_enable;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (do_write && {1'b0, item.entry_slot} == 5'(i)) begin
            tport_ff[i] <= item.port;
            ttags_ff[i] <= item.entry_tags;
            tovid_ff[i] <= item.word_b[11:0];
            tivid_ff[i] <= item.word_d[11:0];
            ttpid_ff[i] <= {item.word_a, item.word_c};
            tlog_ff[i]  <= item.entry_logical;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_logical_id   = out_logical_ff;
   assign rsp_outer_pcp    = out_opcp_ff;
   assign rsp_outer_dei    = out_odei_ff;
   assign rsp_inner_pcp    = out_ipcp_ff;
   assign rsp_inner_dei    = out_idei_ff;
   assign rsp_strip_octets = out_strip_ff;

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      take |-> state_ff == S_IDLE && !out_valid_ff)
      else $error("item taken while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> out_valid_ff)
      else $error("scan ended without result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_status_ff))
      else $error("result dropped under stall");
   a_match_strip: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff != ST_MATCHED |-> out_strip_ff == 4'd0)
      else $error("strip set on non-match");

endmodule

FILE: src/vlan_sap_ingress_classifier_unit.sv
// Top level of the VLAN attachment ingress classifier.
// Depends on vsic_pkg, vsic_queue and vsic_engine.
//
// Each accepted item gives exactly one result, in order. A write item stores
// its entry when the engine takes it; a classify item walks the table one
// slot per cycle, first for the port's contract entry and then for the key,
// through the single slot compare of the scan engine. A two-item queue sits
// in front of the engine, so the request side keeps taking items while a scan
// runs until the queue is full, and the result register holds a finished item
// until rsp_ready takes it. Writes to slots beyond TABLE_ENTRIES are dropped
// but still answer entry written.
module vlan_sap_ingress_classifier_unit #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [15:0] req_port,
   input  logic [15:0] req_frame_length,
   input  logic [15:0] req_hdr_word_a,
   input  logic [15:0] req_hdr_word_b,
   input  logic [15:0] req_hdr_word_c,
   input  logic [15:0] req_hdr_word_d,
   input  logic [15:0] req_hdr_word_e,
   input  logic [3:0]  req_entry_slot,
   input  logic        req_entry_enable,
   input  logic [1:0]  req_entry_tags,
   input  logic [31:0] req_entry_logical,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_logical_id,
   output logic [2:0]  rsp_outer_pcp,
   output logic        rsp_outer_dei,
   output logic [2:0]  rsp_inner_pcp,
   output logic        rsp_inner_dei,
   output logic [3:0]  rsp_strip_octets
);
   import vsic_pkg::*;

   item_type in_item, q_item;
   logic     q_valid, q_ready;

   // pack the request fields into one queue item
   always_comb begin
      in_item.cmd           = req_cmd;
      in_item.port          = req_port;
      in_item.frame_length  = req_frame_length;
      in_item.word_a        = req_hdr_word_a;
      in_item.word_b        = req_hdr_word_b;
      in_item.word_c        = req_hdr_word_c;
      in_item.word_d        = req_hdr_word_d;
      in_item.word_e        = req_hdr_word_e;
      // slots outside the table pass through and match no table entry in the engine
      in_item.entry_slot    = req_entry_slot;
      in_item.entry_enable  = req_entry_enable;
      in_item.entry_tags    = req_entry_tags;
      in_item.entry_logical = req_entry_logical;
   end

   vsic_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (in_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   vsic_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (q_valid),
      .item_ready       (q_ready),
      .item             (q_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_logical_id   (rsp_logical_id),
      .rsp_outer_pcp    (rsp_outer_pcp),
      .rsp_outer_dei    (rsp_outer_dei),
      .rsp_inner_pcp    (rsp_inner_pcp),
      .rsp_inner_dei    (rsp_inner_dei),
      .rsp_strip_octets (rsp_strip_octets)
   );

   a_write_answer: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready && q_item.cmd == CMD_WRITE |=>
         rsp_valid && rsp_status == ST_WRITTEN)
      else $error("write did not answer entry written");
   a_nonmatch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_MATCHED |-> rsp_logical_id == 32'd0)
      else $error("logical id set on non-match");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_logical_id))
      else $error("result changed under stall");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for vlan_sap_ingress_classifier_unit: directed table then random items.
// Depends on vsic_pkg and the classifier RTL; carries its own attachment-table predictor.
`timescale 1ns / 1ps

module tb_top;
   import vsic_pkg::*;

   localparam int SLOTS = 16;
   localparam int RANDOM_ITEMS = 900;

   typedef struct {
      logic        cmd;
      logic [15:0] port;
      logic [15:0] frame_length;
      logic [15:0] w [5];
      logic [3:0]  slot;
      logic        enable;
      logic [1:0]  tags;
      logic [31:0] logical;
   } frame_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] logical_id;
      logic [2:0]  outer_pcp;
      logic        outer_dei;
      logic [2:0]  inner_pcp;
      logic        inner_dei;
      logic [3:0]  strip_octets;
   } verdict_type;

   typedef struct {
      frame_req_type req;
      bit            typed;
      verdict_type   result;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = 1'b0;
   logic [15:0] req_port = '0;
   logic [15:0] req_frame_length = '0;
   logic [15:0] req_hdr_word_a = '0;
   logic [15:0] req_hdr_word_b = '0;
   logic [15:0] req_hdr_word_c = '0;
   logic [15:0] req_hdr_word_d = '0;
   logic [15:0] req_hdr_word_e = '0;
   logic [3:0]  req_entry_slot = '0;
   logic        req_entry_enable = 1'b0;
   logic [1:0]  req_entry_tags = '0;
   logic [31:0] req_entry_logical = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_logical_id;
   logic [2:0]  rsp_outer_pcp;
   logic        rsp_outer_dei;
   logic [2:0]  rsp_inner_pcp;
   logic        rsp_inner_dei;
   logic [3:0]  rsp_strip_octets;

   // Predictor copy of the attachment table.
   bit          tbl_valid   [SLOTS];
   logic [15:0] tbl_port    [SLOTS];
   logic [1:0]  tbl_tags    [SLOTS];
   logic [11:0] tbl_ovid    [SLOTS];
   logic [11:0] tbl_ivid    [SLOTS];
   logic [15:0] tbl_otpid   [SLOTS];
   logic [15:0] tbl_itpid   [SLOTS];
   logic [31:0] tbl_logical [SLOTS];

   verdict_type  pending_verdicts [$];
   stim_row_type rows [$];
   int           fail_count = 0;
   bit           calm = 1'b0;   // no idling on either side while set
   logic [15:0]  port_pool [4];

   vlan_sap_ingress_classifier_unit #(.TABLE_ENTRIES(SLOTS)) dut (.*);

   always #6 clock = ~clock;

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Work out the answer for one accepted item and update the table copy.
   function automatic verdict_type classify_or_store(frame_req_type r);
      verdict_type v;
      int          contract;
      int          hit;
      logic [1:0]  tags;
      logic [11:0] ov;
      logic [11:0] iv;
      logic [15:0] otp;
      logic [15:0] itp;
      logic [15:0] after;
      v = '0;
      contract = -1;
      hit = -1;
      if (r.cmd == CMD_WRITE) begin
         tbl_valid[r.slot]   = r.enable;
         tbl_port[r.slot]    = r.port;
         tbl_tags[r.slot]    = r.tags;
         tbl_ovid[r.slot]    = r.w[1][11:0];
         tbl_ivid[r.slot]    = r.w[3][11:0];
         tbl_otpid[r.slot]   = r.w[0];
         tbl_itpid[r.slot]   = r.w[2];
         tbl_logical[r.slot] = r.logical;
         v.status = ST_WRITTEN;
         return v;
      end
      v.status = ST_NOMATCH;
      for (int i = 0; i < SLOTS; i++)
         if (contract < 0 && tbl_valid[i] && tbl_port[i] == r.port) contract = i;
      if (contract < 0) return v;
      tags = tbl_tags[contract];
      if (tags > 2'd2) return v;
      if (r.frame_length < 16'd14 + 16'd4 * {14'd0, tags}) begin
         v.status = ST_MALFORMED;
         return v;
      end
      otp = tbl_otpid[contract];
      itp = tbl_itpid[contract];
      ov  = tbl_ovid[contract];
      iv  = tbl_ivid[contract];
      if (tags >= 2'd1) begin
         if (r.w[0] != otp) return v;
         ov = r.w[1][11:0];
      end
      if (tags == 2'd2) begin
         if (r.w[2] != itp) return v;
         iv = r.w[3][11:0];
      end
      // A further tag behind the expected ones disqualifies the frame.
      after = r.w[2 * tags];
      if (after == TPID_CTAG || after == TPID_STAG || after == otp ||
          (itp != 16'h0 && after == itp)) return v;
      for (int i = 0; i < SLOTS; i++)
         if (hit < 0 && tbl_valid[i] && tbl_port[i] == r.port && tbl_tags[i] == tags &&
             tbl_ovid[i] == ov && tbl_ivid[i] == iv &&
             tbl_otpid[i] == otp && tbl_itpid[i] == itp) hit = i;
      if (hit < 0) return v;
      v.status = ST_MATCHED;
      v.logical_id = tbl_logical[hit];
      if (tags >= 2'd1) begin
         v.outer_pcp = r.w[1][15:13];
         v.outer_dei = r.w[1][12];
      end
      if (tags == 2'd2) begin
         v.inner_pcp = r.w[3][15:13];
         v.inner_dei = r.w[3][12];
      end
      v.strip_octets = {tags, 2'b00};
      return v;
   endfunction

   function automatic frame_req_type mk_write(logic [3:0] slot, logic en, logic [1:0] tags,
                                              logic [15:0] port, logic [15:0] otp,
                                              logic [15:0] ov, logic [15:0] itp,
                                              logic [15:0] iv, logic [31:0] logical);
      frame_req_type r;
      r.cmd = CMD_WRITE;
      r.port = port;
      r.frame_length = 16'($urandom);
      r.w[0] = otp; r.w[1] = ov; r.w[2] = itp; r.w[3] = iv; r.w[4] = 16'($urandom);
      r.slot = slot; r.enable = en; r.tags = tags; r.logical = logical;
      return r;
   endfunction

   function automatic frame_req_type mk_frame(logic [15:0] port, logic [15:0] len,
                                              logic [15:0] a, logic [15:0] b,
                                              logic [15:0] c, logic [15:0] d,
                                              logic [15:0] e);
      frame_req_type r;
      r.cmd = CMD_CLASSIFY;
      r.port = port;
      r.frame_length = len;
      r.w[0] = a; r.w[1] = b; r.w[2] = c; r.w[3] = d; r.w[4] = e;
      r.slot = 4'($urandom); r.enable = 1'($urandom); r.tags = 2'($urandom);
      r.logical = $urandom;
      return r;
   endfunction

   function automatic logic [15:0] pick_tpid();
      case ($urandom_range(0, 4))
         0: return TPID_CTAG;
         1: return TPID_STAG;
         2: return 16'h9100;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Random write: mostly valid entries on a few ports, some removals and odd tag counts.
   function automatic frame_req_type random_write();
      logic [1:0] tags;
      logic       en;
      tags = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      en = ($urandom_range(0, 99) < 85);
      return mk_write(4'($urandom), en, tags,
                      ($urandom_range(0, 9) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 3)],
                      pick_tpid(), 16'($urandom), pick_tpid(), 16'($urandom), $urandom);
   endfunction

   // Random frame built to fit a stored entry, with random markings and occasional flaws.
   function automatic frame_req_type random_frame();
      frame_req_type r;
      int            s;
      int            start;
      int            t;
      s = -1;
      start = $urandom_range(0, SLOTS - 1);
      for (int i = 0; i < SLOTS; i++)
         if (s < 0 && tbl_valid[(start + i) % SLOTS]) s = (start + i) % SLOTS;
      r = mk_frame(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
      if (s < 0 || $urandom_range(0, 9) == 0) return r;
      t = int'(tbl_tags[s]);
      r.port = tbl_port[s];
      r.frame_length = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 23))
                                                   : 16'($urandom_range(14 + 4 * t, 1518));
      r.w[0] = tbl_otpid[s];
      r.w[1] = {3'($urandom), 1'($urandom), tbl_ovid[s]};
      r.w[2] = tbl_itpid[s];
      r.w[3] = {3'($urandom), 1'($urandom), tbl_ivid[s]};
      if (t < 3) begin
         // hold the word behind the tags clear of any TPID most of the time
         r.w[2 * t] = ($urandom_range(0, 7) == 0) ? pick_tpid() : 16'h0800;
      end
      if ($urandom_range(0, 9) == 0) r.w[$urandom_range(0, 3)] ^= 16'(1 << $urandom_range(0, 15));
      return r;
   endfunction

   // Append one directed row to the stimulus table.
   task automatic add_row(frame_req_type r, bit typed, verdict_type res);
      stim_row_type row;
      row.req = r;
      row.typed = typed;
      row.result = res;
      rows.insert(rows.size(), row);
   endtask

   // Present one item, hold it until accepted, then record its expected answer.
   task automatic send_item(frame_req_type r, bit typed, verdict_type typed_result);
      verdict_type predicted;
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 21) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_cmd = r.cmd;
      req_port = r.port;
      req_frame_length = r.frame_length;
      req_hdr_word_a = r.w[0];
      req_hdr_word_b = r.w[1];
      req_hdr_word_c = r.w[2];
      req_hdr_word_d = r.w[3];
      req_hdr_word_e = r.w[4];
      req_entry_slot = r.slot;
      req_entry_enable = r.enable;
      req_entry_tags = r.tags;
      req_entry_logical = r.logical;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = classify_or_store(r);
      pending_verdicts.insert(pending_verdicts.size(), typed ? typed_result : predicted);
   endtask

   task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0h, got %0h", name, expected, actual);
         fail_count++;
      end
   endtask

   // Result side: random back-pressure, calm while the quiet stretch runs.
   initial forever begin
      @(negedge clock);
      rsp_ready = calm || $urandom_range(0, 99) >= 21;
   end

   always @(posedge clock) begin
      verdict_type exp_v;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("result item with nothing expected, status %0d", rsp_status);
            fail_count++;
         end else begin
            exp_v = pending_verdicts.pop_front();
            check_field("status", 32'(exp_v.status), 32'(rsp_status));
            check_field("logical_id", exp_v.logical_id, rsp_logical_id);
            check_field("outer_pcp", 32'(exp_v.outer_pcp), 32'(rsp_outer_pcp));
            check_field("outer_dei", 32'(exp_v.outer_dei), 32'(rsp_outer_dei));
            check_field("inner_pcp", 32'(exp_v.inner_pcp), 32'(rsp_inner_pcp));
            check_field("inner_dei", 32'(exp_v.inner_dei), 32'(rsp_inner_dei));
            check_field("strip_octets", 32'(exp_v.strip_octets), 32'(rsp_strip_octets));
         end
      end
   end

   function automatic verdict_type status_only(logic [1:0] st);
      verdict_type v;
      v = '0;
      v.status = st;
      return v;
   endfunction

   initial begin
      int wait_cycles;
      for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
      foreach (port_pool[i]) port_pool[i] = 16'($urandom);
      port_pool[0] = 16'h0005;
      port_pool[1] = 16'hFFFF;

      // Empty table, then one entry of each tag count with its edge cases.
      add_row(mk_frame(16'h0005, 16'd64, 16'h0800, 16'h0, 16'h0, 16'h0, 16'h0), 1'b1,
              status_only(ST_NOMATCH));
      add_row(mk_write(4'd0, 1'b1, 2'd0, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                       32'hFFFF_FFFF), 1'b1, status_only(ST_WRITTEN));
      add_row(mk_frame(16'h0005, 16'd14, 16'h0800, 16'h0, 16'h0, 16'h0, 16'h0), 1'b0, '0);
      add_row(mk_frame(16'h0005, 16'd13, 16'h0800, 16'h0, 16'h0, 16'h0, 16'h0), 1'b1,
              status_only(ST_MALFORMED));
      add_row(mk_write(4'd1, 1'b1, 2'd1, 16'h0100, TPID_CTAG, 16'h0123, 16'h0000, 16'h0000,
                       32'h0000_0001), 1'b1, status_only(ST_WRITTEN));
      add_row(mk_frame(16'h0100, 16'd18, TPID_CTAG, 16'hE123, 16'h0800, 16'h0, 16'h0), 1'b0,
              '0);
      add_row(mk_frame(16'h0100, 16'd17, TPID_CTAG, 16'hE123, 16'h0800, 16'h0, 16'h0), 1'b1,
              status_only(ST_MALFORMED));
      add_row(mk_frame(16'h0100, 16'd18, TPID_STAG, 16'hE123, 16'h0800, 16'h0, 16'h0), 1'b1,
              status_only(ST_NOMATCH));
      add_row(mk_frame(16'h0100, 16'd18, TPID_CTAG, 16'hE123, TPID_CTAG, 16'h0, 16'h0), 1'b1,
              status_only(ST_NOMATCH));
      add_row(mk_frame(16'h0100, 16'd18, TPID_CTAG, 16'h1124, 16'h0800, 16'h0, 16'h0), 1'b1,
              status_only(ST_NOMATCH));
      add_row(mk_write(4'd2, 1'b1, 2'd2, 16'hFFFF, TPID_STAG, 16'hFFFF, TPID_CTAG, 16'h0000,
                       32'h0000_0000), 1'b1, status_only(ST_WRITTEN));
      add_row(mk_frame(16'hFFFF, 16'd22, TPID_STAG, 16'hFFFF, TPID_CTAG, 16'h1000,
                       16'h0800), 1'b0, '0);
      add_row(mk_frame(16'hFFFF, 16'd21, TPID_STAG, 16'hFFFF, TPID_CTAG, 16'h1000,
                       16'h0800), 1'b1, status_only(ST_MALFORMED));
      add_row(mk_frame(16'hFFFF, 16'd22, TPID_STAG, 16'hFFFF, 16'h9100, 16'h1000,
                       16'h0800), 1'b1, status_only(ST_NOMATCH));
      add_row(mk_frame(16'hFFFF, 16'd22, TPID_STAG, 16'hFFFF, TPID_CTAG, 16'h1000,
                       TPID_STAG), 1'b1, status_only(ST_NOMATCH));
      // Tag count three is kept but never classifies.
      add_row(mk_write(4'd3, 1'b1, 2'd3, 16'h0007, TPID_CTAG, 16'h0, TPID_CTAG, 16'h0,
                       32'h7), 1'b1, status_only(ST_WRITTEN));
      add_row(mk_frame(16'h0007, 16'hFFFF, TPID_CTAG, 16'h0, TPID_CTAG, 16'h0, 16'h0), 1'b1,
              status_only(ST_NOMATCH));
      // Removal of the untagged entry.
      add_row(mk_write(4'd0, 1'b0, 2'd0, 16'h0005, 16'h0, 16'h0, 16'h0, 16'h0,
                       32'hFFFF_FFFF), 1'b1, status_only(ST_WRITTEN));
      add_row(mk_frame(16'h0005, 16'd64, 16'h0800, 16'h0, 16'h0, 16'h0, 16'h0), 1'b1,
              status_only(ST_NOMATCH));
      // Zero inner TPID does not count as a further tag.
      add_row(mk_write(4'd15, 1'b1, 2'd2, 16'h0000, 16'h9100, 16'h0000, 16'h0000, 16'h0000,
                       32'h8000_0000), 1'b1, status_only(ST_WRITTEN));
      add_row(mk_frame(16'h0000, 16'hFFFF, 16'h9100, 16'h0000, 16'h0000, 16'hF000,
                       16'h0000), 1'b0, '0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) send_item(rows[i].req, rows[i].typed, rows[i].result);

      // Drain before the random part starts.
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 300 && n < 420);
         if ($urandom_range(0, 99) < 30) send_item(random_write(), 1'b0, '0);
         else send_item(random_frame(), 1'b0, '0);
      end
      calm = 1'b0;
      @(negedge clock);
      req_valid = 1'b0;

      wait_cycles = 0;
      while (pending_verdicts.size() != 0 && wait_cycles < 100_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (pending_verdicts.size() != 0) begin
         $error("%0d result items never arrived", pending_verdicts.size());
         fail_count++;
      end
      repeat (80) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: filelist.f
src/vsic_pkg.sv
src/vsic_queue.sv
src/vsic_engine.sv
src/vlan_sap_ingress_classifier_unit.sv
verif/tb_top.sv
